// ===== hw/rtl/ppde_pkg.sv =====
// Shared constants, types and the arctangent table for the point pair
// distance and elevation block. No dependencies.
`default_nettype none

package ppde_pkg;

  localparam int COORD_W     = 16;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int SQ_W        = 2 * DIFF_W;
  localparam int RAD_W       = 50;
  localparam int ROOT_W      = 25;
  localparam int SQRT_STEPS  = ROOT_W;
  localparam int ANGLE_ITERATIONS = 16;
  localparam int CV_W        = 28;
  localparam int ACC_W       = 25;
  localparam int DIST_W      = 18;
  localparam int ANG_W       = 16;
  localparam int DROOT_W     = 21;
  localparam int FRONT_STAGES = 4;
  localparam int PIPE_DEPTH  = FRONT_STAGES + SQRT_STEPS + ANGLE_ITERATIONS;
  localparam int IDX_W       = 5;

  localparam logic signed [ANG_W-1:0] ANGLE_LIMIT = 16'sd23040;
  // floor(r / 10) == (r * DIV10_MUL) >> DIV10_SHIFT for every r below 2^26.
  localparam logic [23:0] DIV10_MUL   = 24'd13421773;
  localparam int          DIV10_SHIFT = 27;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dz;
    logic                     xy_zero;
  } side_t;

  function automatic logic signed [ACC_W-1:0] atan_q16(input logic [IDX_W-1:0] idx);
    logic signed [ACC_W-1:0] v;
    begin
      case (idx)
        5'd0:    v = 25'sd2949120;
        5'd1:    v = 25'sd1740967;
        5'd2:    v = 25'sd919879;
        5'd3:    v = 25'sd466945;
        5'd4:    v = 25'sd234379;
        5'd5:    v = 25'sd117304;
        5'd6:    v = 25'sd58666;
        5'd7:    v = 25'sd29335;
        5'd8:    v = 25'sd14668;
        5'd9:    v = 25'sd7334;
        5'd10:   v = 25'sd3667;
        5'd11:   v = 25'sd1833;
        5'd12:   v = 25'sd917;
        5'd13:   v = 25'sd458;
        5'd14:   v = 25'sd229;
        5'd15:   v = 25'sd115;
        5'd16:   v = 25'sd57;
        5'd17:   v = 25'sd29;
        5'd18:   v = 25'sd14;
        5'd19:   v = 25'sd7;
        5'd20:   v = 25'sd4;
        5'd21:   v = 25'sd2;
        5'd22:   v = 25'sd1;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ppde_sqrt_cell.sv =====
// One digit step of the integer square root chain: tries one root bit
// against the running remainder. Depends on ppde_pkg.
`default_nettype none

module ppde_sqrt_cell (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [ppde_pkg::IDX_W-1:0]    bit_i,
  input  wire logic [ppde_pkg::RAD_W-1:0]    rem_i,
  input  wire logic [ppde_pkg::ROOT_W-1:0]   root_i,
  output logic      [ppde_pkg::RAD_W-1:0]    rem_o,
  output logic      [ppde_pkg::ROOT_W-1:0]   root_o
);
  import ppde_pkg::*;

  logic [RAD_W:0]   trial;
  logic             fits;
  logic [RAD_W-1:0] rem_d;
  logic [ROOT_W-1:0] root_d;

  // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b); the two terms share no bits.
  always_comb begin
    trial  = ((RAD_W + 1)'(root_i) << (bit_i + IDX_W'(1)))
           | ((RAD_W + 1)'(1) << {bit_i, 1'b0});
    fits   = {1'b0, rem_i} >= trial;
    rem_d  = fits ? rem_i - trial[RAD_W-1:0] : rem_i;
    root_d = fits ? root_i | (ROOT_W'(1) << bit_i) : root_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      root_o <= root_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ppde_cordic_cell.sv =====
// One vectoring CORDIC rotation with a fixed shift, registered.
// Depends on ppde_pkg for widths and the arctangent table.
`default_nettype none

module ppde_cordic_cell (
  input  wire logic                               clk_i,
  input  wire logic                               en_i,
  input  wire logic [ppde_pkg::IDX_W-1:0]         shift_i,
  input  wire logic signed [ppde_pkg::CV_W-1:0]   x_i,
  input  wire logic signed [ppde_pkg::CV_W-1:0]   y_i,
  input  wire logic signed [ppde_pkg::ACC_W-1:0]  acc_i,
  output logic      signed [ppde_pkg::CV_W-1:0]   x_o,
  output logic      signed [ppde_pkg::CV_W-1:0]   y_o,
  output logic      signed [ppde_pkg::ACC_W-1:0]  acc_o
);
  import ppde_pkg::*;

  logic signed [CV_W-1:0]  xs, ys, x_d, y_d;
  logic signed [ACC_W-1:0] acc_d;

  always_comb begin
    xs = x_i >>> shift_i;
    ys = y_i >>> shift_i;
    x_d = x_i;
    y_d = y_i;
    acc_d = acc_i;
    // A zero y leaves the vector alone.
    if (!y_i[CV_W-1] && (y_i != '0)) begin
      x_d   = x_i + ys;
      y_d   = y_i - xs;
      acc_d = acc_i + atan_q16(shift_i);
    end else if (y_i[CV_W-1]) begin
      x_d   = x_i - ys;
      y_d   = y_i + xs;
      acc_d = acc_i - atan_q16(shift_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o   <= x_d;
      y_o   <= y_d;
      acc_o <= acc_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/point_pair_distance_elevation.sv =====
// Top level of the point pair distance and elevation block.
// Depends on ppde_pkg, ppde_sqrt_cell and ppde_cordic_cell.
//
// Usage: each slave-side transaction carries two 3D points as six signed
// 16-bit millimetre coordinates. Each master-side transaction returns the
// distance between them in 1/16 cm (rounded down), the elevation angle of
// the line against the xy plane in 1/256 degree, and in tuser a flag that
// is set when the points coincide and the angle has no meaning.
// Throughput is one transaction per cycle while s_axis_tready_o is high.
// The datapath is a row of registered cells: four front stages
// (differences, squares, two sums), 25 square root digit cells for the
// distance root and as many for the horizontal length, side by side, and
// 16 CORDIC rotation cells. The last cell feeds the output register
// through a divide-by-ten multiply and the angle rounding and clamping.
// The whole row advances together. When the receiver stalls, the output
// register holds its result and one more result lands in a skid register;
// only then does s_axis_tready_o fall, and the row freezes until the
// receiver takes a result. Reset empties the row and the output stage;
// no other state exists, and s_axis_tready_o is high right after reset.
`default_nettype none

module point_pair_distance_elevation (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [15:0] first_x, [31:16] first_y, [47:32] first_z,
  // [63:48] second_x, [79:64] second_y, [95:80] second_z
  input  wire logic [95:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [17:0] distance_sixteenth_cm, [33:18] elevation_deg_q8, [39:34] zero
  output logic [39:0]      m_axis_tdata_o,
  // [0] angle_undefined
  output logic             m_axis_tuser_o
);
  import ppde_pkg::*;

  typedef struct packed {
    logic [DIST_W-1:0]       span;
    logic signed [ANG_W-1:0] ang;
    logic                    undef;
  } res_t;

  logic en;
  logic [PIPE_DEPTH-1:0] vld_q;

  // Front stages.
  logic signed [DIFF_W-1:0] dx_q, dy_q, dz1_q;
  logic [SQ_W-1:0] sqx_q, sqy_q, sqz2_q, sqz3_q, sxy3_q, sxy4_q, s4_q;
  side_t side2_q, side3_q;
  logic signed [SQ_W-1:0] px, py, pz;

  // The coordinates travel as 16-bit fields; each is sign-extended by one bit.
  always_comb begin
    px = dx_q * dx_q;
    py = dy_q * dy_q;
    pz = dz1_q * dz1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q  <= DIFF_W'(signed'(s_axis_tdata_i[15:0])) - DIFF_W'(signed'(s_axis_tdata_i[63:48]));
      dy_q  <= DIFF_W'(signed'(s_axis_tdata_i[31:16])) - DIFF_W'(signed'(s_axis_tdata_i[79:64]));
      dz1_q <= DIFF_W'(signed'(s_axis_tdata_i[47:32])) - DIFF_W'(signed'(s_axis_tdata_i[95:80]));
      sqx_q <= px;
      sqy_q <= py;
      sqz2_q <= pz;
      side2_q.dz      <= dz1_q;
      side2_q.xy_zero <= (dx_q == '0) && (dy_q == '0);
      sxy3_q  <= sqx_q + sqy_q;
      sqz3_q  <= sqz2_q;
      side3_q <= side2_q;
      sxy4_q  <= sxy3_q;
      s4_q    <= sxy3_q + sqz3_q;
    end
  end

  // Square root row: distance root of 256*S and horizontal root of 2^16*Sxy.
  logic [RAD_W-1:0]  d_rem  [0:SQRT_STEPS];
  logic [ROOT_W-1:0] d_root [0:SQRT_STEPS];
  logic [RAD_W-1:0]  h_rem  [0:SQRT_STEPS];
  logic [ROOT_W-1:0] h_root [0:SQRT_STEPS];
  side_t side_q [0:SQRT_STEPS+ANGLE_ITERATIONS];
  side_t side4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side4_q <= side3_q;
    end
  end

  assign d_rem[0]  = {8'b0, s4_q, 8'b0};
  assign d_root[0] = '0;
  assign h_rem[0]  = {sxy4_q, 16'b0};
  assign h_root[0] = '0;
  assign side_q[0] = side4_q;

  genvar k;
  generate
    for (k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      ppde_sqrt_cell u_dist_cell (
        .clk_i  (clk_i),
        .en_i   (en),
        .bit_i  (IDX_W'(SQRT_STEPS - 1 - k)),
        .rem_i  (d_rem[k]),
        .root_i (d_root[k]),
        .rem_o  (d_rem[k+1]),
        .root_o (d_root[k+1])
      );
      ppde_sqrt_cell u_horiz_cell (
        .clk_i  (clk_i),
        .en_i   (en),
        .bit_i  (IDX_W'(SQRT_STEPS - 1 - k)),
        .rem_i  (h_rem[k]),
        .root_i (h_root[k]),
        .rem_o  (h_rem[k+1]),
        .root_o (h_root[k+1])
      );
      always_ff @(posedge clk_i) begin
        if (en) begin
          side_q[k+1] <= side_q[k];
        end
      end
    end
  endgenerate

  // CORDIC row; the distance root rides along.
  logic signed [CV_W-1:0]  cx   [0:ANGLE_ITERATIONS];
  logic signed [CV_W-1:0]  cy   [0:ANGLE_ITERATIONS];
  logic signed [ACC_W-1:0] cacc [0:ANGLE_ITERATIONS];
  logic [DROOT_W-1:0]      droot_q [0:ANGLE_ITERATIONS];

  assign cx[0]      = signed'({3'b0, h_root[SQRT_STEPS]});
  assign cy[0]      = signed'({{3{side_q[SQRT_STEPS].dz[DIFF_W-1]}},
                               side_q[SQRT_STEPS].dz, 8'b0});
  assign cacc[0]    = '0;
  assign droot_q[0] = d_root[SQRT_STEPS][DROOT_W-1:0];

  genvar j;
  generate
    for (j = 0; j < ANGLE_ITERATIONS; j++) begin : g_cordic
      ppde_cordic_cell u_cell (
        .clk_i   (clk_i),
        .en_i    (en),
        .shift_i (IDX_W'(j)),
        .x_i     (cx[j]),
        .y_i     (cy[j]),
        .acc_i   (cacc[j]),
        .x_o     (cx[j+1]),
        .y_o     (cy[j+1]),
        .acc_o   (cacc[j+1])
      );
      always_ff @(posedge clk_i) begin
        if (en) begin
          droot_q[j+1]                   <= droot_q[j];
          side_q[SQRT_STEPS+j+1]         <= side_q[SQRT_STEPS+j];
        end
      end
    end
  endgenerate

  // Final scaling: divide the distance root by ten, round the angle to
  // 1/256 degree and clamp it to +-90 degrees, and override the angle for vertical or coincident pairs.
  side_t                   fside;
  logic [DROOT_W+23:0]     dprod;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-9:0] ang_w;
  res_t                    res;

  always_comb begin
    fside = side_q[SQRT_STEPS+ANGLE_ITERATIONS];
    dprod = droot_q[ANGLE_ITERATIONS] * DIV10_MUL;
    acc_r = cacc[ANGLE_ITERATIONS] + ACC_W'(128);
    ang_w = (ACC_W-8)'(acc_r >>> 8);
    res.span  = dprod[DIV10_SHIFT +: DIST_W];
    res.undef = 1'b0;
    if (ang_w > (ACC_W-8)'(ANGLE_LIMIT)) begin
      res.ang = ANGLE_LIMIT;
    end else if (ang_w < -(ACC_W-8)'(ANGLE_LIMIT)) begin
      res.ang = -ANGLE_LIMIT;
    end else begin
      res.ang = ang_w[ANG_W-1:0];
    end
    if (fside.xy_zero) begin
      if (fside.dz == '0) begin
        res.ang   = '0;
        res.undef = 1'b1;
      end else if (fside.dz[DIFF_W-1]) begin
        res.ang = -ANGLE_LIMIT;
      end else begin
        res.ang = ANGLE_LIMIT;
      end
    end
  end

  // Output register plus one skid entry.
  logic out_v_q, skid_v_q, pop, push;
  res_t out_q, skid_q;

  assign en   = !skid_v_q;
  assign pop  = out_v_q && m_axis_tready_i;
  assign push = en && vld_q[PIPE_DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (en) begin
        vld_q <= {vld_q[PIPE_DEPTH-2:0], s_axis_tvalid_i};
      end
      if (skid_v_q) begin
        if (pop) begin
          skid_v_q <= 1'b0;
        end
      end else if (out_v_q && !pop) begin
        skid_v_q <= push;
      end else begin
        out_v_q <= push;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (out_v_q && !pop) begin
      skid_q <= res;
    end else begin
      out_q <= res;
    end
  end

  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {6'b0, out_q.ang, out_q.span};
  assign m_axis_tuser_o  = out_q.undef;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry holds a result while the output register is empty");

  a_undef_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("coincident points must give zero distance and angle");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((out_q.ang <= ANGLE_LIMIT) && (out_q.ang >= -ANGLE_LIMIT)))
    else $error("elevation angle outside +-90 degrees");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> vld_q[0])
    else $error("accepted transaction did not enter the cell row");

endmodule

`default_nettype wire

// ===== dv/ppde_checker.sv =====
// Checker for the point pair distance and elevation block: it watches both
// stream channels, predicts each result and compares it. Depends on ppde_pkg.
`timescale 1ns / 1ps

module ppde_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_valid_i,
  input  wire logic        s_ready_i,
  input  wire logic [95:0] s_data_i,
  input  wire logic        m_valid_i,
  input  wire logic        m_ready_i,
  input  wire logic [39:0] m_data_i,
  input  wire logic        m_user_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               result_count_o
);
  import ppde_pkg::*;

  typedef struct packed {
    logic [17:0]        span;
    logic signed [15:0] elev;
    logic               undef;
  } geom_t;

  geom_t pending_geom_q[$];

  // Bitwise integer square root, floor, of a value below 2^96.
  function automatic longint unsigned root_floor(input logic [95:0] n);
    logic [95:0] r;
    logic [95:0] c;
    r = '0;
    for (int b = 47; b >= 0; b--) begin
      c = r | (96'd1 << b);
      if (c * c <= n) r = c;
    end
    return r[63:0];
  endfunction

  function automatic longint floor_div_pow2(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic geom_t predict_geom(input logic [95:0] d);
    geom_t        g;
    longint       dx, dy, dz, x, y, acc, xs, ys, ang;
    logic [95:0]  sxy, sall;
    dx = longint'($signed(d[15:0])) - longint'($signed(d[63:48]));
    dy = longint'($signed(d[31:16])) - longint'($signed(d[79:64]));
    dz = longint'($signed(d[47:32])) - longint'($signed(d[95:80]));
    sxy  = 96'(dx * dx) + 96'(dy * dy);
    sall = sxy + 96'(dz * dz);
    g.span  = 18'(root_floor(sall << 8) / 10);
    g.undef = 1'b0;
    ang = 0;
    if (dx == 0 && dy == 0) begin
      if (dz > 0) ang = 23040;
      else if (dz < 0) ang = -23040;
      else g.undef = 1'b1;
    end else begin
      x = longint'(root_floor(sxy << 16));
      y = dz * 256;
      acc = 0;
      for (int i = 0; i < ANGLE_ITERATIONS; i++) begin
        xs = floor_div_pow2(x, i);
        ys = floor_div_pow2(y, i);
        if (y > 0) begin
          x += ys; y -= xs; acc += longint'(atan_q16(IDX_W'(i)));
        end else if (y < 0) begin
          x -= ys; y += xs; acc -= longint'(atan_q16(IDX_W'(i)));
        end
      end
      ang = floor_div_pow2(acc + 128, 8);
      if (ang > 23040) ang = 23040;
      if (ang < -23040) ang = -23040;
    end
    g.elev = 16'(ang);
    return g;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH result %0d %s: got %0d expected %0d", result_count_o, what, got, want);
    fail_count_o++;
  endtask

  assign pending_o = pending_geom_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    geom_t want;
    if (!rst_ni) begin
      fail_count_o   <= 0;
      result_count_o <= 0;
    end else begin
      if (s_valid_i && s_ready_i) pending_geom_q.push_back(predict_geom(s_data_i));
      if (m_valid_i && m_ready_i) begin
        if (pending_geom_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = pending_geom_q.pop_front();
          if (m_data_i[17:0] !== want.span)
            report_mismatch("distance", m_data_i[17:0], want.span);
          if (m_data_i[33:18] !== want.elev)
            report_mismatch("elevation", $signed(m_data_i[33:18]), want.elev);
          if (m_data_i[39:34] !== 6'd0)
            report_mismatch("padding", m_data_i[39:34], 0);
          if (m_user_i !== want.undef)
            report_mismatch("undefined flag", m_user_i, want.undef);
        end
        result_count_o <= result_count_o + 1;
      end
    end
  end
endmodule

// ===== dv/tb_top.sv =====
// Testbench top for point_pair_distance_elevation: drives point pairs and
// receiver stalls, and gives the verdict. Depends on ppde_checker and the RTL.
`timescale 1ns / 1ps

module tb_top;
  localparam int LATENCY    = 46;
  localparam int STALL_LIM  = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [95:0] s_data = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [39:0] m_data;
  logic        m_user;
  int          fail_count, pending, result_count;
  int          idle_cycles;
  bit          quiet_sender, quiet_receiver, hold_receiver, stim_done;
  logic [95:0] directed_q[$];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  point_pair_distance_elevation u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready), .s_axis_tdata_i(s_data),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tuser_o(m_user)
  );

  ppde_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_valid_i(s_valid), .s_ready_i(s_ready), .s_data_i(s_data),
    .m_valid_i(m_valid), .m_ready_i(m_ready), .m_data_i(m_data), .m_user_i(m_user),
    .fail_count_o(fail_count), .pending_o(pending), .result_count_o(result_count)
  );

  function automatic logic [95:0] pack_pair(input int ax, ay, az, bx, by, bz);
    return {16'(bz), 16'(by), 16'(bx), 16'(az), 16'(ay), 16'(ax)};
  endfunction

  // Mostly pairs whose points lie close in x and y, so the angle covers its
  // whole range; one case in four spans the full coordinate range.
  function automatic logic [95:0] random_pair();
    int ax, ay, az, sp;
    logic [95:0] v;
    case ($urandom_range(0, 3))
      0: v = {$urandom, $urandom, $urandom};
      1: begin
        ax = $urandom_range(0, 65535) - 32768;
        ay = $urandom_range(0, 65535) - 32768;
        az = $urandom_range(0, 65535) - 32768;
        sp = 1 << $urandom_range(0, 12);
        v = pack_pair(ax, ay, az,
                      ax + $urandom_range(0, 2 * sp) - sp,
                      ay + $urandom_range(0, 2 * sp) - sp,
                      az + $urandom_range(0, 2 * sp) - sp);
      end
      2: begin
        ax = $urandom_range(0, 65535) - 32768;
        ay = $urandom_range(0, 65535) - 32768;
        v = pack_pair(ax, ay, $urandom_range(0, 65535) - 32768,
                      ax + $urandom_range(0, 2), ay, $urandom_range(0, 65535) - 32768);
      end
      default: begin
        ax = $urandom_range(0, 65535) - 32768;
        ay = $urandom_range(0, 65535) - 32768;
        az = $urandom_range(0, 65535) - 32768;
        v = pack_pair(ax, ay, az, ax, ay, az + $urandom_range(0, 6) - 3);
      end
    endcase
    return v;
  endfunction

  // Offer one transaction and hold it until it is taken. Valid stays high
  // afterwards so that transactions can follow back to back; an idle cycle
  // or the caller drops it.
  task automatic send_pair(input logic [95:0] d);
    while (!quiet_sender && $urandom_range(0, 99) < 14) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= d;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Receiver: random ready, plus one long hold-off when asked.
  always @(negedge clk_i) begin
    if (hold_receiver) m_ready <= 1'b0;
    else m_ready <= quiet_receiver || ($urandom_range(0, 99) >= 14);
  end

  // Watchdog on cycles with no transaction on either side.
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready) || hold_receiver) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIM) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    idle_cycles = 0;
    // Directed cases: coincident points, vertical lines both ways, extremes
    // of every field, horizontal lines and a 45 degree line.
    directed_q = '{
      pack_pair(0, 0, 0, 0, 0, 0),
      pack_pair(-32768, -32768, -32768, -32768, -32768, -32768),
      pack_pair(5, 7, 100, 5, 7, -100),
      pack_pair(5, 7, -100, 5, 7, 100),
      pack_pair(0, 0, 32767, 0, 0, -32768),
      pack_pair(0, 0, -32768, 0, 0, 32767),
      pack_pair(32767, 32767, 32767, -32768, -32768, -32768),
      pack_pair(-32768, -32768, -32768, 32767, 32767, 32767),
      pack_pair(32767, 0, 0, -32768, 0, 0),
      pack_pair(0, -32768, 0, 0, 32767, 0),
      pack_pair(1, 0, 0, 0, 0, 0),
      pack_pair(0, 0, 0, 0, 1, 0),
      pack_pair(10, 0, 10, 0, 0, 0),
      pack_pair(0, 10, -10, 0, 0, 0),
      pack_pair(1, 0, 32767, 0, 0, -32768),
      pack_pair(1, 0, -32768, 0, 0, 32767),
      pack_pair(-1, -1, -1, -1, -1, -1),
      pack_pair(32767, 32767, 32767, 32767, 32767, 32767),
      pack_pair(3, 4, 0, 0, 0, 0),
      pack_pair(-1, 0, 1, 0, 0, 0)
    };
    quiet_sender = 1'b0; quiet_receiver = 1'b0; hold_receiver = 1'b0; stim_done = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_q[k]) send_pair(directed_q[k]);

    // Random part with a stretch of no idling on either side.
    for (int n = 0; n < 500; n++) begin
      quiet_sender   = (n >= 150 && n < 250);
      quiet_receiver = quiet_sender;
      if (n == 300) begin
        // Sender pauses until every result has come back.
        s_valid <= 1'b0;
        @(negedge clk_i);
        while (pending != 0) @(negedge clk_i);
      end
      send_pair(random_pair());
    end
    s_valid <= 1'b0;
    stim_done = 1'b1;

    // Final drain with a cap, then the latency tail.
    for (int w = 0; w < 100000 && pending != 0; w++) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
    $display("Covered %0d results: coincident, vertical and extreme pairs plus random pairs,",
             result_count);
    $display("with a long receiver hold-off that filled the pipeline and a full drain midway.");
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Long receiver hold-off while the sender keeps offering, in its own process.
  initial begin
    wait (rst_ni);
    wait (result_count >= 40);
    @(negedge clk_i);
    hold_receiver = 1'b1;
    repeat (200) @(negedge clk_i);
    hold_receiver = 1'b0;
  end
endmodule
